// ===== sv/rgbc_pkg.sv =====
// shared types and constants of the rgb 3x3 convolution block
package rgbc_pkg;

   localparam int CH_W      = 8;
   localparam int ACC_W     = 16;
   localparam int ROW_W     = 12;
   localparam int X_OUT_W   = 10;
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 13;
   localparam int KERNEL_W  = 24;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int SIZE_MIN  = 3;
   localparam int HEIGHT_MAX = 4096;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [KERNEL_W-1:0] KERNEL_SIDE_RESET   = 24'h000000;
   localparam logic [KERNEL_W-1:0] KERNEL_MIDDLE_RESET = 24'h000100;

   typedef logic [CH_W-1:0] chan_type;
   // index 0 red, 1 green, 2 blue
   typedef chan_type [2:0] rgb_type;
   // index 0 top row, 1 middle row, 2 bottom row
   typedef rgb_type [2:0] col_type;
   // per channel column sums, index as rgb_type
   typedef logic [2:0][ACC_W-1:0] part_type;

   typedef struct packed {
      logic shift;
      logic calc;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_KERNEL_LEFT,
      REG_KERNEL_MIDDLE,
      REG_KERNEL_RIGHT
   } reg_index_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [9:0]  pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic        run_end;
   } rsp_type;

endpackage

// ===== sv/rgbc_line_buf.sv =====
// two line buffers holding the rows one and two above the current pixel
module rgbc_line_buf import rgbc_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rgb_type                  wr_pix,
   output rgb_type                  rd_older,
   output rgb_type                  rd_prev
);

   rgb_type older_mem [DEPTH];
   rgb_type prev_mem  [DEPTH];
   rgb_type older_rd_ff;
   rgb_type prev_rd_ff;

   // read data is registered; the row above moves up one store on write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         older_rd_ff <= older_mem[rd_addr];
         prev_rd_ff  <= prev_mem[rd_addr];
      end
      if (wr_en) begin
         older_mem[wr_addr] <= prev_rd_ff;
         prev_mem[wr_addr]  <= wr_pix;
      end
   end

   assign rd_older = older_rd_ff;
   assign rd_prev  = prev_rd_ff;

endmodule

// ===== sv/rgbc_col_cell.sv =====
// one window column: holds three pixels and forms its weighted column sum
module rgbc_col_cell import rgbc_pkg::*; (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [KERNEL_W-1:0] kernel,
   input  col_type             col_in,
   output col_type             col_out,
   output part_type            part_out
);

   col_type  col_ff;
   part_type part_ff;
   part_type part_in;

   always_comb begin
      logic signed [CH_W+8:0] prod;
      logic [ACC_W-1:0]       acc;
      for (int ch = 0; ch < 3; ch++) begin
         acc = '0;
         for (int dy = 0; dy < 3; dy++) begin
            prod = $signed({1'b0, col_ff[dy][ch]}) * $signed(kernel[8*dy +: 8]);
            acc  = acc + prod[ACC_W-1:0];
         end
         part_in[ch] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         col_ff <= col_in;
      end
      if (ctrl.calc) begin
         part_ff <= part_in;
      end
   end

   assign col_out  = col_ff;
   assign part_out = part_ff;

endmodule

// ===== sv/rgb_conv3x3_clip.sv =====
// top level of the rgb 3x3 convolution with clipping and border pass-through
//
// rgb_conv3x3_clip filters a raster-order rgb stream with one signed 3x3
// kernel applied to each channel. an input word is taken every clock while
// the result side keeps up; a pixel that both completes an interior pixel
// and lies on the right border or the bottom row gives two result words
// and holds the input while both wait in the single result register.
// each input word passes the line buffer read, the window cells, the
// column sums, then sum and clip into the result register. interior
// pixel (x,y) comes from the window that pixel (x+1,y+1) completes; border
// pixels go with their own input, after any interior pixel of it, and
// run_end marks the last result of each input. the line buffers are not
// cleared after reset: the first two rows of a frame only fill them, and
// no interior result reads an entry that was not written in the running
// frame. sums wrap at 16 bits before clipping to 0..255. the user must
// write configuration through the csr port only while no word is in
// flight; the block itself does not enforce this.
module rgb_conv3x3_clip import rgbc_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // pixel input
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // configuration
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
   localparam int XW   = (CW > X_OUT_W) ? CW : X_OUT_W;

   typedef struct packed {
      logic [CW-1:0]    col;
      logic [ROW_W-1:0] row;
      rgb_type          pix;
      logic             interior;
      logic             border;
   } meta_type;

   // configuration registers
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [KERNEL_W-1:0] kern_ff [3];
   logic                csr_wr;
   reg_index_type       csr_idx;

   // position counters of the next input word
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // pipeline stage valids and tags
   logic     v1_ff, v2_ff, v3_ff;
   meta_type m1_ff, m2_ff, m3_ff, m1_in;

   // result register: up to an interior and a border word
   logic    has_int_ff, has_brd_ff, has_int_in, has_brd_in;
   rsp_type int_rsp_ff, brd_rsp_ff, int_rsp_in, brd_rsp_in;

   logic go;
   logic accept;

   // size clamping and border tests
   logic [CMPW-1:0]     w_reg_ext, w_eff, col_next_ext;
   logic [HEIGHT_W-1:0] h_eff, row_next_ext;
   logic                last_col, last_row;

   // window and line buffer
   rgb_type       rd_older, rd_prev;
   col_type       new_col;
   col_type       cell_col [3];
   part_type      cell_part [3];
   cell_ctrl_type cell_ctrl;

   logic [XW-1:0] int_x_ext, brd_x_ext;

   // ---------------------------------------------------------------
   // configuration port, always ready, writes on the access phase
   // ---------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         kern_ff[0] <= KERNEL_SIDE_RESET;
         kern_ff[1] <= KERNEL_MIDDLE_RESET;
         kern_ff[2] <= KERNEL_SIDE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_IMAGE_WIDTH:   width_ff   <= pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  height_ff  <= pwdata[HEIGHT_W-1:0];
            REG_KERNEL_LEFT:   kern_ff[0] <= pwdata[KERNEL_W-1:0];
            REG_KERNEL_MIDDLE: kern_ff[1] <= pwdata[KERNEL_W-1:0];
            REG_KERNEL_RIGHT:  kern_ff[2] <= pwdata[KERNEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IMAGE_WIDTH:   prdata = CSR_DW'(width_ff);
         REG_IMAGE_HEIGHT:  prdata = CSR_DW'(height_ff);
         REG_KERNEL_LEFT:   prdata = CSR_DW'(kern_ff[0]);
         REG_KERNEL_MIDDLE: prdata = CSR_DW'(kern_ff[1]);
         REG_KERNEL_RIGHT:  prdata = CSR_DW'(kern_ff[2]);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // flow control: the whole pipe moves when the result register
   // is empty or hands out its last word this clock
   // ---------------------------------------------------------------
   assign go        = !(has_int_ff || has_brd_ff) || (!rsp_stall && (has_int_ff ^ has_brd_ff));
   assign req_stall = !go;
   assign accept    = req_valid && go;

   // ---------------------------------------------------------------
   // position tracking, frame size clamped to 3..max
   // ---------------------------------------------------------------
   always_comb begin
      w_reg_ext = CMPW'(width_ff);
      if (w_reg_ext < CMPW'(SIZE_MIN)) begin
         w_eff = CMPW'(SIZE_MIN);
      end else if (w_reg_ext > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = w_reg_ext;
      end

      if (height_ff < HEIGHT_W'(SIZE_MIN)) begin
         h_eff = HEIGHT_W'(SIZE_MIN);
      end else if (height_ff > HEIGHT_W'(HEIGHT_MAX)) begin
         h_eff = HEIGHT_W'(HEIGHT_MAX);
      end else begin
         h_eff = height_ff;
      end

      col_next_ext = CMPW'(col_ff) + CMPW'(1);
      row_next_ext = HEIGHT_W'(row_ff) + HEIGHT_W'(1);
      // a position at or past a shrunk size counts as that border
      last_col     = col_next_ext >= w_eff;
      last_row     = row_next_ext >= h_eff;

      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_next_ext[ROW_W-1:0];
      end else begin
         col_in = col_next_ext[CW-1:0];
      end

      m1_in.col      = col_ff;
      m1_in.row      = row_ff;
      m1_in.pix[0]   = req_data.in_red;
      m1_in.pix[1]   = req_data.in_green;
      m1_in.pix[2]   = req_data.in_blue;
      m1_in.interior = (col_ff >= CW'(2)) && (row_ff >= ROW_W'(2));
      m1_in.border   = (col_ff == '0) || (row_ff == '0) || last_col || last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------
   // stage valids and tags
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (go) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         m1_ff <= m1_in;
         m2_ff <= m1_ff;
         m3_ff <= m2_ff;
      end
   end

   // ---------------------------------------------------------------
   // line buffers: read at the new column as it enters, written back later
   // ---------------------------------------------------------------
   rgbc_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock    (clock),
      .rd_en    (go),
      .rd_addr  (col_ff),
      .wr_en    (go && v1_ff),
      .wr_addr  (m1_ff.col),
      .wr_pix   (m1_ff.pix),
      .rd_older (rd_older),
      .rd_prev  (rd_prev)
   );

   // ---------------------------------------------------------------
   // window: three column cells, the newest column enters on the right
   // and every column moves one cell left per pixel
   // ---------------------------------------------------------------
   always_comb begin
      new_col[0]      = rd_older;
      new_col[1]      = rd_prev;
      new_col[2]      = m1_ff.pix;
      cell_ctrl.shift = go && v1_ff;
      cell_ctrl.calc  = go;
   end

   for (genvar k = 0; k < 3; k++) begin : g_cell
      rgbc_col_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .kernel   (kern_ff[k]),
         .col_in   ((k == 2) ? new_col : cell_col[(k == 2) ? k : k + 1]),
         .col_out  (cell_col[k]),
         .part_out (cell_part[k])
      );
   end

   // ---------------------------------------------------------------
   // final sum of the column sums, wrapped to 16 bits, then clipped
   // ---------------------------------------------------------------
   function automatic chan_type clip_sum(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b,
                                         logic [ACC_W-1:0] c);
      logic [ACC_W-1:0] s;
      s = a + b + c;
      if (s[ACC_W-1]) begin
         return '0;
      end else if (s >= ACC_W'(255)) begin
         return '1;
      end
      return s[CH_W-1:0];
   endfunction

   always_comb begin
      int_x_ext = XW'(m3_ff.col - CW'(1));
      brd_x_ext = XW'(m3_ff.col);

      int_rsp_in.pixel_x   = int_x_ext[X_OUT_W-1:0];
      int_rsp_in.pixel_y   = m3_ff.row - ROW_W'(1);
      int_rsp_in.out_red   = clip_sum(cell_part[0][0], cell_part[1][0], cell_part[2][0]);
      int_rsp_in.out_green = clip_sum(cell_part[0][1], cell_part[1][1], cell_part[2][1]);
      int_rsp_in.out_blue  = clip_sum(cell_part[0][2], cell_part[1][2], cell_part[2][2]);
      int_rsp_in.run_end   = !m3_ff.border;

      brd_rsp_in.pixel_x   = brd_x_ext[X_OUT_W-1:0];
      brd_rsp_in.pixel_y   = m3_ff.row;
      brd_rsp_in.out_red   = m3_ff.pix[0];
      brd_rsp_in.out_green = m3_ff.pix[1];
      brd_rsp_in.out_blue  = m3_ff.pix[2];
      brd_rsp_in.run_end   = 1'b1;
   end

   // ---------------------------------------------------------------
   // result register, interior word goes out before the border word
   // ---------------------------------------------------------------
   always_comb begin
      has_int_in = has_int_ff;
      has_brd_in = has_brd_ff;
      if (go) begin
         has_int_in = v3_ff && m3_ff.interior;
         has_brd_in = v3_ff && m3_ff.border;
      end else if (!rsp_stall) begin
         // both words held, the interior one leaves
         has_int_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_int_ff <= 1'b0;
         has_brd_ff <= 1'b0;
      end else begin
         has_int_ff <= has_int_in;
         has_brd_ff <= has_brd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         int_rsp_ff <= int_rsp_in;
         brd_rsp_ff <= brd_rsp_in;
      end
   end

   assign rsp_valid = has_int_ff || has_brd_ff;
   assign rsp_data  = has_int_ff ? int_rsp_ff : brd_rsp_ff;

endmodule

// ===== sv/rgbc_checker.sv =====
// port checker of the rgb 3x3 convolution block and its bind
module rgbc_checker import rgbc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with nothing waiting on the result side the input is never held
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while no result is pending");

   // an interior word that is not last is followed by the border word of
   // the pixel one down and one right
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.run_end |=>
         rsp_valid && rsp_data.run_end &&
         (rsp_data.pixel_x == $past(rsp_data.pixel_x) + 10'd1) &&
         (rsp_data.pixel_y == $past(rsp_data.pixel_y) + 12'd1))
      else $error("second result of a pixel missing or misplaced");

endmodule

bind rgb_conv3x3_clip rgbc_checker u_rgbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
